@@ design/md5_pkg.sv @@
package md5_pkg;

   localparam int WORD_W    = 32;
   localparam int BUF_WORDS = 16;
   localparam int ROUNDS    = 64;
   localparam int WADDR_W   = $clog2(BUF_WORDS);
   localparam int BADDR_W   = $clog2(BUF_WORDS * 4);
   localparam int RND_W     = $clog2(ROUNDS);

   localparam logic [7:0] PAD_MARK = 8'h80;
   localparam logic [BADDR_W-1:0] LEN_POS  = BADDR_W'(56);
   localparam logic [BADDR_W-1:0] LAST_POS = BADDR_W'(63);

   typedef logic [3:0][WORD_W-1:0] chain_type;

   localparam chain_type CHAIN_IV = {32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301};

   typedef struct packed {
      logic start;
      logic init;
   } core_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } core_stat_type;

   localparam logic [WORD_W-1:0] K_TABLE [ROUNDS] = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
      32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
      32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
      32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
      32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
      32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
      32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
      32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
      32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
      32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
      32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
   };

   // indexed by {phase, round mod 4}
   localparam logic [4:0] ROT_TABLE [16] = '{
      5'd7, 5'd12, 5'd17, 5'd22,
      5'd5, 5'd9,  5'd14, 5'd20,
      5'd4, 5'd11, 5'd16, 5'd23,
      5'd6, 5'd10, 5'd15, 5'd21
   };

   function automatic logic [WADDR_W-1:0] msg_index(input logic [RND_W-1:0] rnd);
      logic [WADDR_W-1:0] r4;
      logic [WADDR_W-1:0] idx;
      r4 = rnd[WADDR_W-1:0];
      case (rnd[RND_W-1:RND_W-2])
         2'd0: idx = r4;
         2'd1: idx = WADDR_W'(r4 * WADDR_W'(5) + WADDR_W'(1));
         2'd2: idx = WADDR_W'(r4 * WADDR_W'(3) + WADDR_W'(5));
         default: idx = WADDR_W'(r4 * WADDR_W'(7));
      endcase
      return idx;
   endfunction

endpackage

@@ design/md5_channels_if.sv @@
interface md5_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_value;
   logic       has_byte;
   logic       last_byte;

   modport source (output valid, output byte_value, output has_byte, output last_byte,
                   input ready);
   modport sink (input valid, input byte_value, input has_byte, input last_byte,
                 output ready);
endinterface

interface md5_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] digest_half;
   logic        final_half;

   modport source (output valid, output digest_half, output final_half, input ready);
   modport sink (input valid, input digest_half, input final_half, output ready);
endinterface

@@ design/md5_blk_buf.sv @@
module md5_blk_buf (
   input  logic                           clock,
   input  logic                           wr_en,
   input  logic [md5_pkg::BADDR_W-1:0]    wr_addr,
   input  logic [7:0]                     wr_byte,
   input  logic [md5_pkg::WADDR_W-1:0]    rd_addr,
   output logic [md5_pkg::WORD_W-1:0]     rd_data
);

   logic [md5_pkg::WORD_W-1:0] words_mem [md5_pkg::BUF_WORDS];
   logic [md5_pkg::WORD_W-1:0] rd_data_ff;

   // byte lane write, little-endian within a word
   always_ff @(posedge clock) begin
      if (wr_en) begin
         words_mem[wr_addr[md5_pkg::BADDR_W-1:2]][{wr_addr[1:0], 3'b000} +: 8] <= wr_byte;
      end
      rd_data_ff <= words_mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/md5_round_core.sv @@
module md5_round_core (
   input  logic                          clock,
   input  logic                          reset,
   input  md5_pkg::core_ctl_type         ctl,
   output md5_pkg::core_stat_type        stat,
   output logic [md5_pkg::WADDR_W-1:0]   rd_addr,
   input  logic [md5_pkg::WORD_W-1:0]    rd_data,
   output md5_pkg::chain_type            chain
);

   typedef enum logic [1:0] {C_IDLE, C_ROUND, C_ADD} core_state_type;

   core_state_type             state_ff, state_in;
   logic [md5_pkg::RND_W-1:0]  rnd_ff, rnd_in;
   logic [md5_pkg::WORD_W-1:0] a_ff, b_ff, c_ff, d_ff;
   logic [md5_pkg::WORD_W-1:0] a_in, b_in, c_in, d_in;
   md5_pkg::chain_type         chain_ff, chain_in;

   logic [md5_pkg::WORD_W-1:0] f_val;
   logic [md5_pkg::WORD_W-1:0] sum_val;
   logic [2*md5_pkg::WORD_W-1:0] dbl_val;
   logic [4:0]                 sh_amt;

   always_comb begin
      case (rnd_ff[md5_pkg::RND_W-1:md5_pkg::RND_W-2])
         2'd0: f_val = (b_ff & c_ff) | (~b_ff & d_ff);
         2'd1: f_val = (b_ff & d_ff) | (c_ff & ~d_ff);
         2'd2: f_val = b_ff ^ c_ff ^ d_ff;
         default: f_val = c_ff ^ (b_ff | ~d_ff);
      endcase
      sum_val = a_ff + f_val + md5_pkg::K_TABLE[rnd_ff] + rd_data;
      sh_amt  = md5_pkg::ROT_TABLE[{rnd_ff[md5_pkg::RND_W-1:md5_pkg::RND_W-2], rnd_ff[1:0]}];
      dbl_val = {sum_val, sum_val} << sh_amt;
   end

   always_comb begin
      state_in = state_ff;
      rnd_in   = rnd_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      c_in     = c_ff;
      d_in     = d_ff;
      chain_in = chain_ff;
      case (state_ff)
         C_IDLE: begin
            if (ctl.start) begin
               a_in     = chain_ff[0];
               b_in     = chain_ff[1];
               c_in     = chain_ff[2];
               d_in     = chain_ff[3];
               rnd_in   = '0;
               state_in = C_ROUND;
            end else if (ctl.init) begin
               chain_in = md5_pkg::CHAIN_IV;
            end
         end
         C_ROUND: begin
            a_in   = d_ff;
            d_in   = c_ff;
            c_in   = b_ff;
            b_in   = b_ff + dbl_val[2*md5_pkg::WORD_W-1:md5_pkg::WORD_W];
            rnd_in = rnd_ff + 1'b1;
            if (rnd_ff == md5_pkg::RND_W'(md5_pkg::ROUNDS - 1)) begin
               state_in = C_ADD;
            end
         end
         C_ADD: begin
            chain_in[0] = chain_ff[0] + a_ff;
            chain_in[1] = chain_ff[1] + b_ff;
            chain_in[2] = chain_ff[2] + c_ff;
            chain_in[3] = chain_ff[3] + d_ff;
            state_in    = C_IDLE;
         end
         default: state_in = C_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= C_IDLE;
         rnd_ff   <= '0;
         chain_ff <= md5_pkg::CHAIN_IV;
      end else begin
         state_ff <= state_in;
         rnd_ff   <= rnd_in;
         chain_ff <= chain_in;
      end
      a_ff <= a_in;
      b_ff <= b_in;
      c_ff <= c_in;
      d_ff <= d_in;
   end

   // fetch the message word for the next round ahead, through the registered buffer read
   assign rd_addr   = (state_ff == C_ROUND) ? md5_pkg::msg_index(rnd_ff + 1'b1) : '0;
   assign stat.busy = (state_ff != C_IDLE);
   assign stat.done = (state_ff == C_ADD);
   assign chain     = chain_ff;

endmodule

@@ design/md5_message_digest.sv @@
// streaming md5: one byte item accepted per cycle while a block fills
// a full 64-byte block then runs 64 rounds, one round a cycle, and a final add step
// input is held off while the single round unit compresses, so filling and compression do not overlap
// finalize: up to 72 padding writes and at most two compressions, then two digest items
// synchronous active-high reset restores the initial chaining words and a zero bit count
module md5_message_digest (
   input logic           clock,
   input logic           reset,
   md5_req_if.sink       req_ch,
   md5_rsp_if.source     rsp_ch
);

   typedef enum logic [2:0] {S_IDLE, S_PAD, S_COMP, S_OUT0, S_OUT1} top_state_type;

   top_state_type                  state_ff, state_in;
   logic [md5_pkg::BADDR_W-1:0]    pos_ff, pos_in;
   logic [63:0]                    bit_count_ff, bit_count_in;
   logic                           mark_ff, mark_in;
   logic                           len_ok_ff, len_ok_in;
   logic                           resume_pad_ff, resume_pad_in;
   logic                           go_out_ff, go_out_in;

   logic                           buf_wr_en;
   logic [7:0]                     buf_wr_byte;
   logic [md5_pkg::WADDR_W-1:0]    buf_rd_addr;
   logic [md5_pkg::WORD_W-1:0]     buf_rd_data;
   md5_pkg::core_ctl_type          core_ctl;
   md5_pkg::core_stat_type         core_stat;
   md5_pkg::chain_type             chain;
   logic                           req_take;

   md5_blk_buf u_buf (
      .clock   (clock),
      .wr_en   (buf_wr_en),
      .wr_addr (pos_ff),
      .wr_byte (buf_wr_byte),
      .rd_addr (buf_rd_addr),
      .rd_data (buf_rd_data)
   );

   md5_round_core u_core (
      .clock   (clock),
      .reset   (reset),
      .ctl     (core_ctl),
      .stat    (core_stat),
      .rd_addr (buf_rd_addr),
      .rd_data (buf_rd_data),
      .chain   (chain)
   );

   assign req_ch.ready = (state_ff == S_IDLE) && !core_stat.busy;
   assign req_take     = req_ch.valid && req_ch.ready;

   assign rsp_ch.valid       = (state_ff == S_OUT0) || (state_ff == S_OUT1);
   assign rsp_ch.final_half  = (state_ff == S_OUT1);
   assign rsp_ch.digest_half = (state_ff == S_OUT1) ? {chain[3], chain[2]}
                                                    : {chain[1], chain[0]};

   always_comb begin
      state_in      = state_ff;
      pos_in        = pos_ff;
      bit_count_in  = bit_count_ff;
      mark_in       = mark_ff;
      len_ok_in     = len_ok_ff;
      resume_pad_in = resume_pad_ff;
      go_out_in     = go_out_ff;
      buf_wr_en     = 1'b0;
      buf_wr_byte   = req_ch.byte_value;
      core_ctl      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               if (req_ch.has_byte) begin
                  buf_wr_en    = 1'b1;
                  pos_in       = pos_ff + 1'b1;
                  bit_count_in = bit_count_ff + 64'd8;
               end
               if (req_ch.last_byte) begin
                  mark_in   = 1'b1;
                  len_ok_in = 1'b0;
               end
               if (req_ch.has_byte && (pos_ff == md5_pkg::LAST_POS)) begin
                  core_ctl.start = 1'b1;
                  resume_pad_in  = req_ch.last_byte;
                  go_out_in      = 1'b0;
                  state_in       = S_COMP;
               end else if (req_ch.last_byte) begin
                  state_in = S_PAD;
               end
            end
         end
         S_PAD: begin
            buf_wr_en = 1'b1;
            pos_in    = pos_ff + 1'b1;
            mark_in   = 1'b0;
            if (mark_ff) begin
               buf_wr_byte = md5_pkg::PAD_MARK;
               len_ok_in   = (pos_ff < md5_pkg::LEN_POS);
            end else if (len_ok_ff && (pos_ff >= md5_pkg::LEN_POS)) begin
               // length bytes, little-endian, byte i at position 56 + i
               buf_wr_byte = 8'(bit_count_ff >> {pos_ff[2:0], 3'b000});
            end else begin
               buf_wr_byte = 8'h00;
            end
            if (pos_ff == md5_pkg::LAST_POS) begin
               core_ctl.start = 1'b1;
               resume_pad_in  = 1'b1;
               go_out_in      = len_ok_ff && !mark_ff;
               len_ok_in      = 1'b1;
               state_in       = S_COMP;
            end
         end
         S_COMP: begin
            if (core_stat.done) begin
               if (go_out_ff) begin
                  state_in = S_OUT0;
               end else if (resume_pad_ff) begin
                  state_in = S_PAD;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_OUT0: begin
            if (rsp_ch.ready) begin
               state_in = S_OUT1;
            end
         end
         S_OUT1: begin
            if (rsp_ch.ready) begin
               core_ctl.init = 1'b1;
               pos_in        = '0;
               bit_count_in  = '0;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         pos_ff        <= '0;
         bit_count_ff  <= '0;
         mark_ff       <= 1'b0;
         len_ok_ff     <= 1'b0;
         resume_pad_ff <= 1'b0;
         go_out_ff     <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pos_ff        <= pos_in;
         bit_count_ff  <= bit_count_in;
         mark_ff       <= mark_in;
         len_ok_ff     <= len_ok_in;
         resume_pad_ff <= resume_pad_in;
         go_out_ff     <= go_out_in;
      end
   end

`ifndef ASSERT_OFF
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      core_ctl.start |=> core_stat.busy)
      else $error("compression did not start");

   a_no_write_busy: assert property (@(posedge clock) disable iff (reset)
      buf_wr_en |-> !core_stat.busy)
      else $error("block buffer written during compression");

   a_rsp_idle_core: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> !core_stat.busy)
      else $error("digest shown while compression runs");

   a_pos_tracks_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> pos_ff == bit_count_ff[8:3])
      else $error("byte position out of step with bit count");
`endif

endmodule

@@ bench/md5_message_digest_tb.sv @@
`timescale 1ns / 1ps

module md5_message_digest_tb;

   localparam int RANDOM_ITEMS = 1200;
   localparam int HOLD_CYCLES  = 600;
   localparam int HOLD_AFTER   = 200;
   localparam int DRAIN_CYCLES = 300;
   localparam int MAX_REPORTS  = 10;

   localparam logic [31:0] IV_A = 32'h67452301;
   localparam logic [31:0] IV_B = 32'hefcdab89;
   localparam logic [31:0] IV_C = 32'h98badcfe;
   localparam logic [31:0] IV_D = 32'h10325476;
   localparam logic [7:0]  PAD_BYTE = 8'h80;
   localparam logic [5:0]  LEN_OFFSET = 6'd56;

   localparam logic [31:0] SINE_K [64] = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
      32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
      32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
      32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
      32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
      32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
      32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
      32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
      32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
      32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
      32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
   };

   localparam int SHIFT_AMT [4][4] = '{
      '{7, 12, 17, 22},
      '{5, 9, 14, 20},
      '{4, 11, 16, 23},
      '{6, 10, 15, 21}
   };

   typedef enum logic [1:0] {
      PH_STEADY,
      PH_SRC_GAPS,
      PH_SNK_STALLS,
      PH_BOTH_GAPS
   } gap_phase_type;

   typedef struct packed {
      logic [7:0] value;
      logic       has;
      logic       last;
   } msg_item_type;

   typedef struct packed {
      logic [63:0] half;
      logic        fin;
   } digest_item_type;

   logic clock;
   logic reset;

   md5_req_if req_bus ();
   md5_rsp_if rsp_bus ();

   md5_message_digest uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus)
   );

   msg_item_type    msg_items [$];
   digest_item_type pending_digest [$];

   // predictor state
   logic [31:0] hash_words [4];
   logic [7:0]  block_bytes [64];
   logic [63:0] msg_bits;
   logic [5:0]  fill_pos;

   int total_items;
   int issued;
   int accepted;
   int error_count;
   int hold_left;
   bit hold_done;

   function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
      return (x << n) | (x >> (32 - n));
   endfunction

   function automatic void md5_compress();
      logic [31:0] m [16];
      logic [31:0] a, b, c, d, f, t;
      int g;
      int ph;
      for (int i = 0; i < 16; i++)
         m[i] = {block_bytes[4*i+3], block_bytes[4*i+2], block_bytes[4*i+1], block_bytes[4*i]};
      a = hash_words[0];
      b = hash_words[1];
      c = hash_words[2];
      d = hash_words[3];
      for (int r = 0; r < 64; r++) begin
         ph = r / 16;
         case (ph)
            0: begin
               f = (b & c) | (~b & d);
               g = r;
            end
            1: begin
               f = (b & d) | (c & ~d);
               g = (5 * r + 1) % 16;
            end
            2: begin
               f = b ^ c ^ d;
               g = (3 * r + 5) % 16;
            end
            default: begin
               f = c ^ (b | ~d);
               g = (7 * r) % 16;
            end
         endcase
         t = d;
         d = c;
         c = b;
         b = b + rotl(a + f + SINE_K[r] + m[g], SHIFT_AMT[ph][r % 4]);
         a = t;
      end
      hash_words[0] += a;
      hash_words[1] += b;
      hash_words[2] += c;
      hash_words[3] += d;
   endfunction

   function automatic void md5_absorb(input logic [7:0] v);
      block_bytes[fill_pos] = v;
      fill_pos = fill_pos + 6'd1;
      if (fill_pos == 6'd0)
         md5_compress();
   endfunction

   function automatic void md5_restart();
      hash_words[0] = IV_A;
      hash_words[1] = IV_B;
      hash_words[2] = IV_C;
      hash_words[3] = IV_D;
      msg_bits = '0;
      fill_pos = '0;
   endfunction

   function automatic void md5_take_item(input msg_item_type it);
      logic [63:0] len;
      digest_item_type lo, hi;
      if (it.has) begin
         md5_absorb(it.value);
         msg_bits = msg_bits + 64'd8;
      end
      if (it.last) begin
         len = msg_bits;
         md5_absorb(PAD_BYTE);
         while (fill_pos != LEN_OFFSET)
            md5_absorb(8'h00);
         for (int i = 0; i < 8; i++)
            md5_absorb(len[8*i +: 8]);
         lo.half = {hash_words[1], hash_words[0]};
         lo.fin  = 1'b0;
         hi.half = {hash_words[3], hash_words[2]};
         hi.fin  = 1'b1;
         pending_digest.push_back(lo);
         pending_digest.push_back(hi);
         md5_restart();
      end
   endfunction

   function automatic gap_phase_type current_phase();
      int idx;
      idx = (total_items == 0) ? 0 : (accepted * 4) / total_items;
      if (idx > 3)
         idx = 3;
      return gap_phase_type'(idx);
   endfunction

   function automatic bit sender_idle();
      gap_phase_type ph;
      ph = current_phase();
      if (ph == PH_SRC_GAPS)
         return $urandom_range(99) < 81;
      if (ph == PH_BOTH_GAPS)
         return $urandom_range(99) < 21;
      return 1'b0;
   endfunction

   function automatic bit receiver_stall();
      gap_phase_type ph;
      ph = current_phase();
      if (ph == PH_SNK_STALLS)
         return $urandom_range(99) < 81;
      if (ph == PH_BOTH_GAPS)
         return $urandom_range(99) < 21;
      return 1'b0;
   endfunction

   function automatic void report_error(input string msg);
      if (error_count < MAX_REPORTS)
         $display("mismatch: %s", msg);
      error_count++;
   endfunction

   function automatic void queue_item(input logic [7:0] v, input logic h, input logic l);
      msg_item_type it;
      it.value = v;
      it.has   = h;
      it.last  = l;
      msg_items.push_back(it);
   endfunction

   // lengths around the padding boundaries get extra weight
   function automatic int pick_length();
      int edges [10] = '{54, 55, 56, 57, 63, 64, 65, 119, 120, 128};
      case ($urandom_range(9))
         0, 1, 2, 3: return $urandom_range(20);
         4, 5, 6:    return edges[$urandom_range(9)];
         default:    return $urandom_range(130);
      endcase
   endfunction

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      reset = 1'b1;
      req_bus.valid      = 1'b0;
      req_bus.byte_value = 8'h00;
      req_bus.has_byte   = 1'b0;
      req_bus.last_byte  = 1'b0;
      rsp_bus.ready      = 1'b0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
   end

   initial begin
      #5_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   // stimulus and end of run
   initial begin
      int counted;
      int len;
      issued = 0;
      accepted = 0;
      error_count = 0;
      md5_restart();
      for (int i = 0; i < 64; i++)
         block_bytes[i] = 8'h00;

      // empty message on a fresh state, byte value must be ignored
      queue_item(8'h5A, 1'b0, 1'b1);
      // idle item between messages
      queue_item(8'hC3, 1'b0, 1'b0);
      // "abc" with last on the final byte
      queue_item(8'h61, 1'b1, 1'b0);
      queue_item(8'h62, 1'b1, 1'b0);
      queue_item(8'h63, 1'b1, 1'b1);
      // idle inside a message, then finalise with no byte
      queue_item(8'h00, 1'b1, 1'b0);
      queue_item(8'hAA, 1'b0, 1'b0);
      queue_item(8'hFF, 1'b1, 1'b0);
      queue_item(8'h00, 1'b0, 1'b1);
      queue_item(8'hFF, 1'b1, 1'b1);
      queue_item(8'h80, 1'b1, 1'b0);
      queue_item(8'h7F, 1'b1, 1'b1);
      queue_item(8'hFF, 1'b0, 1'b1);

      counted = 0;
      while (counted < RANDOM_ITEMS) begin
         len = pick_length();
         for (int i = 0; i < len; i++) begin
            if ($urandom_range(99) < 4)
               queue_item(8'($urandom_range(255)), 1'b0, 1'b0);
            if (i == len - 1 && $urandom_range(1))
               queue_item(8'($urandom_range(255)), 1'b1, 1'b1);
            else
               queue_item(8'($urandom_range(255)), 1'b1, 1'b0);
            counted++;
         end
         if (len == 0 || !msg_items[msg_items.size()-1].last) begin
            queue_item(8'($urandom_range(255)), 1'b0, 1'b1);
            counted++;
         end
      end
      total_items = msg_items.size();

      @(negedge clock);
      while (reset || msg_items.size() != 0 || accepted != issued)
         @(posedge clock);
      while (pending_digest.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_digest.size() != 0)
         report_error($sformatf("%0d digest items never arrived", pending_digest.size()));
      if (error_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   // sender: inputs move on the falling edge
   always @(negedge clock) begin
      msg_item_type it;
      if (!reset && (!req_bus.valid || accepted == issued)) begin
         if (msg_items.size() != 0 && !sender_idle()) begin
            it = msg_items.pop_front();
            req_bus.byte_value <= it.value;
            req_bus.has_byte   <= it.has;
            req_bus.last_byte  <= it.last;
            req_bus.valid      <= 1'b1;
            issued <= issued + 1;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // receiver, with one long hold-off so the block backs up onto its input
   always @(negedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         hold_left <= 0;
         hold_done <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_bus.ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (!hold_done && accepted >= HOLD_AFTER) begin
         rsp_bus.ready <= 1'b0;
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else begin
         rsp_bus.ready <= !receiver_stall();
      end
   end

   // monitor: accepted items feed the predictor, digest items are checked in order
   always @(posedge clock) begin
      msg_item_type it;
      digest_item_type want;
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            it.value = req_bus.byte_value;
            it.has   = req_bus.has_byte;
            it.last  = req_bus.last_byte;
            md5_take_item(it);
            accepted++;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (pending_digest.size() == 0) begin
               report_error($sformatf("unexpected digest item %h final %b",
                                      rsp_bus.digest_half, rsp_bus.final_half));
            end else begin
               want = pending_digest.pop_front();
               if (rsp_bus.digest_half !== want.half)
                  report_error($sformatf("digest_half expected %h got %h",
                                         want.half, rsp_bus.digest_half));
               if (rsp_bus.final_half !== want.fin)
                  report_error($sformatf("final_half expected %b got %b",
                                         want.fin, rsp_bus.final_half));
            end
         end
      end
   end

endmodule

@@ md5_message_digest.f @@
design/md5_pkg.sv
design/md5_channels_if.sv
design/md5_blk_buf.sv
design/md5_round_core.sv
design/md5_message_digest.sv
bench/md5_message_digest_tb.sv
